// File: rtl/indexed_min_priority_queue_core_assert.svh
// Assertion macros used by the queue sequencer.
`ifndef INDEXED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define INDEXED_MIN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IMPQ_ASSERT_CLK(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
	else $error("impq assertion failed");
`define IMPQ_ASSERT(lbl, prop) `IMPQ_ASSERT_CLK(lbl, clk, arst_n, prop)
`else
`define IMPQ_ASSERT_CLK(lbl, ck, rn, prop)
`define IMPQ_ASSERT(lbl, prop)
`endif
`endif

// File: rtl/impq_pkg.sv
// Shared constants of the indexed min priority queue.
package impq_pkg;
	localparam int DEF_MAX_ITEMS    = 64;
	localparam int DEF_TIME_BITS    = 32;
	localparam int DEF_PARTNER_BITS = 16;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 2;
	localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
	localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;
endpackage

// File: rtl/impq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module impq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/impq_ctrl.sv
// Command sequencer: lookup, swim and sink over the heap and slot memories.
`include "indexed_min_priority_queue_core_assert.svh"
module impq_ctrl #(
	parameter int MAX_ITEMS    = impq_pkg::DEF_MAX_ITEMS,
	parameter int TIME_BITS    = impq_pkg::DEF_TIME_BITS,
	parameter int PARTNER_BITS = impq_pkg::DEF_PARTNER_BITS,
	localparam int IDX_W = $clog2(MAX_ITEMS),
	localparam int CNT_W = $clog2(MAX_ITEMS + 1),
	localparam int E_W   = IDX_W + TIME_BITS + PARTNER_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [impq_pkg::CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0]          item_index,
	input  logic [TIME_BITS-1:0]      event_time,
	input  logic [PARTNER_BITS-1:0]   partner_id,
	input  logic                      stored_stale,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      top_present,
	output logic [IDX_W-1:0]          top_index,
	output logic [TIME_BITS-1:0]      top_time,
	output logic [PARTNER_BITS-1:0]   top_partner,
	output logic [CNT_W-1:0]          entry_count,
	output logic [impq_pkg::STAT_W-1:0] status,
	output logic                      h_we,
	output logic [CNT_W-1:0]          h_waddr,
	output logic [E_W-1:0]            h_wdata,
	output logic [CNT_W-1:0]          h_raddr,
	input  logic [E_W-1:0]            h_rdata,
	output logic                      sl_we,
	output logic [IDX_W-1:0]          sl_waddr,
	output logic [CNT_W-1:0]          sl_wdata,
	output logic [IDX_W-1:0]          sl_raddr,
	input  logic [CNT_W-1:0]          sl_rdata
);
	typedef enum logic [10:0] {
		ST_IDLE     = 11'b00000000001,
		ST_CHK      = 11'b00000000010,
		ST_CHK2     = 11'b00000000100,
		ST_POP      = 11'b00000001000,
		ST_SWIM_RQ  = 11'b00000010000,
		ST_SWIM_CMP = 11'b00000100000,
		ST_SINK_RQ  = 11'b00001000000,
		ST_SINK_L   = 11'b00010000000,
		ST_SINK_R   = 11'b00100000000,
		ST_TOP_RQ   = 11'b01000000000,
		ST_TOP      = 11'b10000000000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d, s_q, s_d;
	logic out_valid_q, out_valid_d, load_out;
	logic [impq_pkg::CMD_W-1:0] cmd_q;
	logic [IDX_W-1:0] idx_q;
	logic [TIME_BITS-1:0] time_q;
	logic [PARTNER_BITS-1:0] partner_q;
	logic stale_q, latch_in;
	logic [E_W-1:0] cur_q, cur_d, left_q, left_d, child_e;
	logic [CNT_W-1:0] child_s;
	logic [impq_pkg::STAT_W-1:0] status_q, status_d;
	logic go_dec, do_ins;
	logic [CNT_W:0] lc, rc;
	logic [IDX_W-1:0] rd_item, cur_item, child_item;
	logic [TIME_BITS-1:0] rd_time, cur_time, left_time, child_time;

	assign lc = {s_q, 1'b0};
	assign rc = {s_q, 1'b1};
	assign rd_item    = h_rdata[E_W-1 -: IDX_W];
	assign rd_time    = h_rdata[PARTNER_BITS +: TIME_BITS];
	assign cur_item   = cur_q[E_W-1 -: IDX_W];
	assign cur_time   = cur_q[PARTNER_BITS +: TIME_BITS];
	assign left_time  = left_q[PARTNER_BITS +: TIME_BITS];
	assign child_item = child_e[E_W-1 -: IDX_W];
	assign child_time = child_e[PARTNER_BITS +: TIME_BITS];

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		s_d = s_q;
		cur_d = cur_q;
		left_d = left_q;
		status_d = status_q;
		latch_in = 1'b0;
		load_out = 1'b0;
		go_dec = 1'b0;
		do_ins = 1'b0;
		child_e = h_rdata;
		child_s = lc[CNT_W-1:0];
		h_raddr = s_q;
		h_we = 1'b0;
		h_waddr = s_q;
		h_wdata = cur_q;
		sl_we = 1'b0;
		sl_waddr = cur_item;
		sl_wdata = s_q;
		sl_raddr = item_index;
		case (state_q)
			ST_IDLE: begin
				h_raddr = cnt_q;
				if (in_valid) begin
					latch_in = 1'b1;
					status_d = impq_pkg::STAT_DONE;
					state_d = ST_TOP_RQ;
					case (cmd)
						impq_pkg::CMD_PUSH: begin
							if (int'(item_index) >= MAX_ITEMS)
								status_d = impq_pkg::STAT_IGNORED;
							else
								state_d = ST_CHK;
						end
						impq_pkg::CMD_POP: begin
							if (cnt_q == '0)
								status_d = impq_pkg::STAT_EMPTY;
							else
								state_d = ST_POP;
						end
						impq_pkg::CMD_CLEAR: cnt_d = '0;
						default: ;
					endcase
				end
			end
			ST_CHK: begin
				if (sl_rdata != '0 && sl_rdata <= cnt_q) begin
					h_raddr = sl_rdata;
					s_d = sl_rdata;
					state_d = ST_CHK2;
				end else begin
					do_ins = 1'b1;
				end
			end
			ST_CHK2: begin
				if (rd_item == idx_q) begin
					if (!stale_q && time_q > rd_time) begin
						status_d = impq_pkg::STAT_IGNORED;
						state_d = ST_TOP_RQ;
					end else begin
						cur_d = {idx_q, time_q, partner_q};
						state_d = ST_SWIM_RQ;
					end
				end else begin
					do_ins = 1'b1;
				end
			end
			ST_POP: begin
				cur_d = h_rdata;
				cnt_d = cnt_q - 1'b1;
				s_d = CNT_W'(1);
				state_d = (cnt_q == CNT_W'(1)) ? ST_TOP_RQ : ST_SINK_RQ;
			end
			ST_SWIM_RQ: begin
				h_raddr = s_q >> 1;
				state_d = (s_q == CNT_W'(1)) ? ST_SINK_RQ : ST_SWIM_CMP;
			end
			ST_SWIM_CMP: begin
				if (rd_time > cur_time) begin
					h_we = 1'b1;
					h_wdata = h_rdata;
					sl_we = 1'b1;
					sl_waddr = rd_item;
					s_d = s_q >> 1;
					state_d = ST_SWIM_RQ;
				end else begin
					state_d = ST_SINK_RQ;
				end
			end
			ST_SINK_RQ: begin
				if (lc > {1'b0, cnt_q}) begin
					h_we = 1'b1;
					sl_we = 1'b1;
					state_d = ST_TOP_RQ;
				end else begin
					h_raddr = lc[CNT_W-1:0];
					state_d = ST_SINK_L;
				end
			end
			ST_SINK_L: begin
				left_d = h_rdata;
				if (lc < {1'b0, cnt_q}) begin
					h_raddr = rc[CNT_W-1:0];
					state_d = ST_SINK_R;
				end else begin
					go_dec = 1'b1;
				end
			end
			ST_SINK_R: begin
				go_dec = 1'b1;
				if (left_time > rd_time) begin
					child_s = rc[CNT_W-1:0];
				end else begin
					child_e = left_q;
				end
			end
			ST_TOP_RQ: begin
				h_raddr = CNT_W'(1);
				state_d = ST_TOP;
			end
			ST_TOP: begin
				h_raddr = CNT_W'(1);
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (do_ins) begin
			if (int'(cnt_q) < MAX_ITEMS) begin
				cnt_d = cnt_q + 1'b1;
				s_d = cnt_q + 1'b1;
				cur_d = {idx_q, time_q, partner_q};
				state_d = ST_SWIM_RQ;
			end else begin
				status_d = impq_pkg::STAT_IGNORED;
				state_d = ST_TOP_RQ;
			end
		end
		if (go_dec) begin
			h_we = 1'b1;
			sl_we = 1'b1;
			if (cur_time > child_time) begin
				h_wdata = child_e;
				sl_waddr = child_item;
				s_d = child_s;
				state_d = ST_SINK_RQ;
			end else begin
				state_d = ST_TOP_RQ;
			end
		end
		out_valid_d = load_out | (out_valid_q & ~out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		s_q <= s_d;
		cur_q <= cur_d;
		left_q <= left_d;
		status_q <= status_d;
		if (latch_in) begin
			cmd_q <= cmd;
			idx_q <= item_index;
			time_q <= event_time;
			partner_q <= partner_id;
			stale_q <= stored_stale;
		end
		if (load_out) begin
			top_present <= (cnt_q != '0);
			top_index <= (cnt_q != '0) ? rd_item : '0;
			top_time <= (cnt_q != '0) ? rd_time : '0;
			top_partner <= (cnt_q != '0) ? h_rdata[PARTNER_BITS-1:0] : '0;
			entry_count <= cnt_q;
			status <= (cmd_q == impq_pkg::CMD_CLEAR) ? impq_pkg::STAT_DONE : status_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`IMPQ_ASSERT(a_cnt_max, int'(cnt_q) <= MAX_ITEMS)
	`IMPQ_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready)
	`IMPQ_ASSERT(a_result_from_top, $rose(out_valid_q) |-> $past(state_q == ST_TOP))
	`IMPQ_ASSERT(a_write_pair, h_we |-> sl_we)
endmodule

// File: rtl/indexed_min_priority_queue_core.sv
// Indexed binary min-heap of pending events: top level.
// Usage:
//  Input channel (in_valid/in_ready) takes one command per transaction:
//  push (item_index, event_time, partner_id, stored_stale), pop minimum, or clear.
//  Output channel (out_valid/out_ready) returns one result per command: the
//  earliest event after the command, the entry count and a status code.
//  Commands are processed one at a time. A push looks up the item's slot and
//  checks the heap entry it names, then swims the entry up and sinks it; a
//  pop moves the last entry to the root and sinks it. The pace is set by the
//  heap memory's single read port: every parent or child visited costs one
//  registered read.
//  The result register decouples the sides: a new command is accepted while
//  a result waits; a stalled receiver holds the next result in the sequencer.
//  Reset empties the queue at once; no memory sweep is needed since slot
//  lookups are validated against the heap contents and the count.
module indexed_min_priority_queue_core #(
	parameter int MAX_ITEMS    = impq_pkg::DEF_MAX_ITEMS,
	parameter int TIME_BITS    = impq_pkg::DEF_TIME_BITS,
	parameter int PARTNER_BITS = impq_pkg::DEF_PARTNER_BITS,
	localparam int IDX_W = $clog2(MAX_ITEMS),
	localparam int CNT_W = $clog2(MAX_ITEMS + 1),
	localparam int E_W   = IDX_W + TIME_BITS + PARTNER_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [impq_pkg::CMD_W-1:0] cmd,
	input  logic [IDX_W-1:0]          item_index,
	input  logic [TIME_BITS-1:0]      event_time,
	input  logic [PARTNER_BITS-1:0]   partner_id,
	input  logic                      stored_stale,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      top_present,
	output logic [IDX_W-1:0]          top_index,
	output logic [TIME_BITS-1:0]      top_time,
	output logic [PARTNER_BITS-1:0]   top_partner,
	output logic [CNT_W-1:0]          entry_count,
	output logic [impq_pkg::STAT_W-1:0] status
);
	logic h_we, sl_we;
	logic [CNT_W-1:0] h_waddr, h_raddr, sl_wdata, sl_rdata;
	logic [E_W-1:0] h_wdata, h_rdata;
	logic [IDX_W-1:0] sl_waddr, sl_raddr;

	impq_ram #(.WIDTH(E_W), .DEPTH(MAX_ITEMS + 1)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	impq_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ITEMS)) u_slot (
		.clk(clk), .we(sl_we), .waddr(sl_waddr), .wdata(sl_wdata),
		.raddr(sl_raddr), .rdata(sl_rdata)
	);

	impq_ctrl #(
		.MAX_ITEMS(MAX_ITEMS), .TIME_BITS(TIME_BITS), .PARTNER_BITS(PARTNER_BITS)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.item_index(item_index), .event_time(event_time),
		.partner_id(partner_id), .stored_stale(stored_stale),
		.out_valid(out_valid), .out_ready(out_ready),
		.top_present(top_present), .top_index(top_index), .top_time(top_time),
		.top_partner(top_partner), .entry_count(entry_count), .status(status),
		.h_we(h_we), .h_waddr(h_waddr), .h_wdata(h_wdata),
		.h_raddr(h_raddr), .h_rdata(h_rdata),
		.sl_we(sl_we), .sl_waddr(sl_waddr), .sl_wdata(sl_wdata),
		.sl_raddr(sl_raddr), .sl_rdata(sl_rdata)
	);
endmodule
